>>> rtl/tgad_pkg.sv
// Shared types and constants for the TGA stream decoder.
// Holds the transfer structs, the parser state record and header byte offsets.
// No dependencies.
package tgad_pkg;

   // Parser phase.
   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_ID     = 3'd1,
      PH_RAW    = 3'd2,
      PH_PACKET = 3'd3,
      PH_PDATA  = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   // Result kind codes.
   typedef enum logic [1:0] {
      KIND_PIXEL      = 2'd0,
      KIND_HEADER_OK  = 2'd1,
      KIND_HEADER_BAD = 2'd2
   } kind_type;

   // Header byte offsets.
   localparam logic [4:0] HDR_ID_LEN     = 5'd0;
   localparam logic [4:0] HDR_COLOR_MAP  = 5'd1;
   localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
   localparam logic [4:0] HDR_DEPTH      = 5'd16;
   localparam logic [4:0] HDR_DESCRIPTOR = 5'd17;

   // Image type codes that the decoder supports.
   localparam logic [7:0] TYPE_TRUE_COLOR     = 8'd2;
   localparam logic [7:0] TYPE_GRAY           = 8'd3;
   localparam logic [7:0] TYPE_RLE_TRUE_COLOR = 8'd10;
   localparam logic [7:0] TYPE_RLE_GRAY       = 8'd11;

   // Pixel depth codes in bits per pixel.
   localparam logic [7:0] DEPTH_8  = 8'd8;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   // Descriptor bit that marks top-first row order.
   localparam int unsigned DESC_TOP_BIT = 5;

   // One transfer on the input channel.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_file;
   } req_item_type;

   // One transfer on the result channel.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [2:0]  pixel_bytes;
      logic        top_origin;
      logic        run_coded;
      logic        last_of_image;
   } rsp_item_type;

   // Parser state. The remaining image is kept as one pixel count.
   typedef struct packed {
      phase_type   phase;
      logic [4:0]  header_index;
      logic        header_bad;
      logic        coded_flag;
      logic [2:0]  depth_bytes;
      logic [15:0] width_store;
      logic [15:0] height_store;
      logic [31:0] pixels_left;
      logic [7:0]  id_bytes_left;
      logic [31:0] pixel_gather;
      logic [1:0]  byte_in_pixel;
      logic [7:0]  packet_left;
      logic        packet_is_run;
      logic        origin_flag;
   } dec_state_type;

   localparam dec_state_type STATE_RESET = '{
      phase:         PH_HEADER,
      header_index:  5'd0,
      header_bad:    1'b0,
      coded_flag:    1'b0,
      depth_bytes:   3'd0,
      width_store:   16'd0,
      height_store:  16'd0,
      pixels_left:   32'd0,
      id_bytes_left: 8'd0,
      pixel_gather:  32'd0,
      byte_in_pixel: 2'd0,
      packet_left:   8'd0,
      packet_is_run: 1'b0,
      origin_flag:   1'b0
   };

   // Bytes per pixel for a depth byte; zero for an unsupported depth.
   function automatic logic [2:0] depth_to_bytes(input logic [7:0] depth);
      logic [2:0] bytes;
      begin
         unique case (depth)
            DEPTH_8:  bytes = 3'd1;
            DEPTH_24: bytes = 3'd3;
            DEPTH_32: bytes = 3'd4;
            default:  bytes = 3'd0;
         endcase
         return bytes;
      end
   endfunction

endpackage

>>> rtl/tgad_step.sv
// Combinational parser step: next parser state and result for one byte.
// Depends on tgad_pkg.
module tgad_step (
   input  tgad_pkg::dec_state_type state_q,
   input  tgad_pkg::req_item_type  item,
   output tgad_pkg::dec_state_type state_d,
   output logic                    rsp_fire,
   output tgad_pkg::rsp_item_type  rsp_item
);

   tgad_pkg::dec_state_type cur;
   logic [7:0]  b;
   logic [31:0] gather;
   logic [31:0] swapped;
   logic        pixel_done;
   logic [7:0]  req_repeat;
   logic [7:0]  count;
   logic        image_end;
   logic        empty_image;
   logic        pixel_phase;

   // Start of the pixel data, right after the header or the ID field.
   function automatic tgad_pkg::dec_state_type enter_data(input tgad_pkg::dec_state_type s);
      tgad_pkg::dec_state_type r;
      begin
         r = s;
         r.pixel_gather  = 32'd0;
         r.byte_in_pixel = 2'd0;
         r.packet_left   = 8'd0;
         r.packet_is_run = 1'b0;
         r.phase         = s.coded_flag ? tgad_pkg::PH_PACKET : tgad_pkg::PH_RAW;
         return r;
      end
   endfunction

   // Shared terms. A new file restarts the parser before this byte is used.
   always_comb begin
      cur         = item.new_file ? tgad_pkg::STATE_RESET : state_q;
      b           = item.data_byte;
      gather      = cur.pixel_gather | ({24'd0, b} << {cur.byte_in_pixel, 3'b000});
      pixel_done  = ({1'b0, cur.byte_in_pixel} + 3'd1) >= cur.depth_bytes;
      pixel_phase = (cur.phase == tgad_pkg::PH_RAW) || (cur.phase == tgad_pkg::PH_PDATA);
      req_repeat  = ((cur.phase == tgad_pkg::PH_PDATA) && cur.packet_is_run) ?
                    cur.packet_left : 8'd1;
      // Clamp the repeat to the pixels left in the image.
      count       = (cur.pixels_left < {24'd0, req_repeat}) ?
                    cur.pixels_left[7:0] : req_repeat;
      image_end   = cur.pixels_left <= {24'd0, req_repeat};
      empty_image = (cur.width_store == 16'd0) || (cur.height_store == 16'd0);
      // Red and blue trade places for color pixels.
      swapped     = (cur.depth_bytes > 3'd1) ?
                    {gather[31:24], gather[7:0], gather[15:8], gather[23:16]} : gather;
   end

   // Next parser state.
   always_comb begin
      state_d = cur;
      unique case (cur.phase)
         tgad_pkg::PH_HEADER: begin
            case (cur.header_index)
               tgad_pkg::HDR_ID_LEN: state_d.id_bytes_left = b;
               tgad_pkg::HDR_COLOR_MAP: begin
                  if (b != 8'd0) state_d.header_bad = 1'b1;
               end
               tgad_pkg::HDR_IMAGE_TYPE: begin
                  state_d.coded_flag = (b == tgad_pkg::TYPE_RLE_TRUE_COLOR) ||
                                       (b == tgad_pkg::TYPE_RLE_GRAY);
                  if ((b != tgad_pkg::TYPE_TRUE_COLOR) && (b != tgad_pkg::TYPE_GRAY) &&
                      (b != tgad_pkg::TYPE_RLE_TRUE_COLOR) &&
                      (b != tgad_pkg::TYPE_RLE_GRAY)) begin
                     state_d.header_bad = 1'b1;
                  end
               end
               tgad_pkg::HDR_WIDTH_LO:  state_d.width_store[7:0]   = b;
               tgad_pkg::HDR_WIDTH_HI:  state_d.width_store[15:8]  = b;
               tgad_pkg::HDR_HEIGHT_LO: state_d.height_store[7:0]  = b;
               tgad_pkg::HDR_HEIGHT_HI: state_d.height_store[15:8] = b;
               tgad_pkg::HDR_DEPTH: begin
                  state_d.depth_bytes = tgad_pkg::depth_to_bytes(b);
                  if (tgad_pkg::depth_to_bytes(b) == 3'd0) state_d.header_bad = 1'b1;
               end
               tgad_pkg::HDR_DESCRIPTOR: state_d.origin_flag = b[tgad_pkg::DESC_TOP_BIT];
               default: ;
            endcase
            if (cur.header_index != tgad_pkg::HDR_DESCRIPTOR) begin
               state_d.header_index = cur.header_index + 5'd1;
            end else if (cur.header_bad || empty_image) begin
               state_d.phase = tgad_pkg::PH_DONE;
            end else begin
               // The image size is the only product; it is taken once per file.
               state_d.pixels_left = {16'd0, cur.width_store} * {16'd0, cur.height_store};
               if (cur.id_bytes_left != 8'd0) begin
                  state_d.phase = tgad_pkg::PH_ID;
               end else begin
                  state_d = enter_data(state_d);
               end
            end
         end
         tgad_pkg::PH_ID: begin
            state_d.id_bytes_left = cur.id_bytes_left - 8'd1;
            if (cur.id_bytes_left == 8'd1) state_d = enter_data(state_d);
         end
         tgad_pkg::PH_PACKET: begin
            if (!b[7]) begin
               state_d.packet_is_run = 1'b0;
               state_d.packet_left   = b + 8'd1;
            end else begin
               state_d.packet_is_run = 1'b1;
               state_d.packet_left   = {1'b0, b[6:0]} + 8'd1;
            end
            state_d.pixel_gather  = 32'd0;
            state_d.byte_in_pixel = 2'd0;
            state_d.phase         = tgad_pkg::PH_PDATA;
         end
         tgad_pkg::PH_RAW, tgad_pkg::PH_PDATA: begin
            if (!pixel_done) begin
               state_d.pixel_gather  = gather;
               state_d.byte_in_pixel = cur.byte_in_pixel + 2'd1;
            end else begin
               if (cur.phase == tgad_pkg::PH_PDATA) begin
                  if (cur.packet_is_run || (cur.packet_left == 8'd1)) begin
                     state_d.packet_left = 8'd0;
                     state_d.phase       = tgad_pkg::PH_PACKET;
                  end else begin
                     state_d.packet_left = cur.packet_left - 8'd1;
                  end
               end
               state_d.pixels_left   = cur.pixels_left - {24'd0, count};
               state_d.pixel_gather  = 32'd0;
               state_d.byte_in_pixel = 2'd0;
               if (image_end) state_d.phase = tgad_pkg::PH_DONE;
            end
         end
         tgad_pkg::PH_DONE: ;
         default: ;
      endcase
   end

   // Result for this byte, if any.
   always_comb begin
      rsp_fire = 1'b0;
      rsp_item = '0;
      if ((cur.phase == tgad_pkg::PH_HEADER) &&
          (cur.header_index == tgad_pkg::HDR_DESCRIPTOR)) begin
         rsp_fire = 1'b1;
         if (cur.header_bad) begin
            rsp_item.kind = tgad_pkg::KIND_HEADER_BAD;
         end else begin
            rsp_item.kind          = tgad_pkg::KIND_HEADER_OK;
            rsp_item.image_width   = cur.width_store;
            rsp_item.image_height  = cur.height_store;
            rsp_item.pixel_bytes   = cur.depth_bytes;
            rsp_item.top_origin    = b[tgad_pkg::DESC_TOP_BIT];
            rsp_item.run_coded     = cur.coded_flag;
            rsp_item.last_of_image = empty_image;
         end
      end else if (pixel_phase && pixel_done) begin
         rsp_fire               = 1'b1;
         rsp_item.kind          = tgad_pkg::KIND_PIXEL;
         rsp_item.pixel_value   = swapped;
         rsp_item.repeat_count  = count;
         rsp_item.last_of_image = image_end;
      end
   end

endmodule

>>> rtl/tga_stream_decoder_core.sv
// TGA stream decoder: one file byte per transfer in, header and pixel results out.
// Each result passes the input register, then the result register. Throughput: one
// byte per cycle unless the result stalls, set by the single parser step.
// Synchronous active-high reset clears both registers' valid flags and the parser,
// which then waits at header byte 0. Depends on tgad_pkg and tgad_step.
module tga_stream_decoder_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tgad_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tgad_pkg::rsp_item_type rsp_data
);

   logic                    in_valid_ff;
   tgad_pkg::req_item_type  in_item_ff;
   tgad_pkg::dec_state_type state_ff;
   tgad_pkg::dec_state_type state_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   tgad_pkg::rsp_item_type  out_item_ff;
   logic                    step_fire;
   tgad_pkg::rsp_item_type  step_item;
   logic                    proceed;

   // The held byte moves on once the result register is free or draining.
   assign proceed   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !proceed;

   // Input register: takes a transfer whenever it is empty or moving on.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
   end

   tgad_step u_step (
      .state_q  (state_ff),
      .item     (in_item_ff),
      .state_d  (state_in),
      .rsp_fire (step_fire),
      .rsp_item (step_item)
   );

   // Parser state advances once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgad_pkg::STATE_RESET;
      end else if (proceed) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_comb begin
      if (proceed) begin
         out_valid_in = step_fire;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proceed && step_fire) begin
         out_item_ff <= step_item;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

>>> rtl/tgad_checker.sv
// Port-level checks for the TGA stream decoder core, and the bind that attaches them.
// Depends on tgad_pkg and tga_stream_decoder_core.
module tgad_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input tgad_pkg::rsp_item_type rsp_data
);

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result transfer holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Pixel repeat counts stay between one and one full packet.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == tgad_pkg::KIND_PIXEL) |->
         (rsp_data.repeat_count != 8'd0) && (rsp_data.repeat_count <= 8'd128))
      else $error("pixel repeat count out of range");

   // An accepted header reports a supported pixel size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == tgad_pkg::KIND_HEADER_OK) |->
         (rsp_data.pixel_bytes == 3'd1) || (rsp_data.pixel_bytes == 3'd3) ||
         (rsp_data.pixel_bytes == 3'd4))
      else $error("accepted header with unsupported pixel size");

endmodule

bind tga_stream_decoder_core tgad_checker u_tgad_checker (.*);

>>> bench/tga_stream_decoder_checker.sv
`timescale 1ns / 100ps
// Result checker for the TGA stream decoder bench: watches both channels, predicts
// each result from the accepted file bytes and compares the results field by field.
// Depends on tgad_pkg for the transfer structs, phase and kind codes and header offsets.
module tga_stream_decoder_checker
   import tgad_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_item_type rsp_data,
   output int           error_count,
   output int           pending_count,
   output int           live_bytes,
   output int           pixel_count,
   output int           header_count,
   output int           rejected_count
);

   localparam int REPORT_LIMIT = 10;

   // Parser state as the bench tracks it. The rest of the image is one pixel count.
   phase_type   stage;
   logic [4:0]  hdr_pos;
   logic        hdr_broken;
   logic        rle_file;
   logic [2:0]  bpp;
   logic [15:0] img_w;
   logic [15:0] img_h;
   logic [31:0] pix_remaining;
   logic [7:0]  id_skip;
   logic [31:0] gather;
   logic [1:0]  gather_pos;
   logic [7:0]  pkt_count;
   logic        pkt_run;
   logic        top_first;

   // Decoder results still to arrive, oldest first.
   rsp_item_type awaited_results[$];

   int errors = 0;
   int results_seen = 0;
   int live = 0;
   int pixels = 0;
   int headers = 0;
   int rejects = 0;

   function automatic void restart_parser();
      stage         = PH_HEADER;
      hdr_pos       = '0;
      hdr_broken    = 1'b0;
      rle_file      = 1'b0;
      bpp           = '0;
      img_w         = '0;
      img_h         = '0;
      pix_remaining = '0;
      id_skip       = '0;
      gather        = '0;
      gather_pos    = '0;
      pkt_count     = '0;
      pkt_run       = 1'b0;
      top_first     = 1'b0;
   endfunction

   // Entry to the pixel data: run-coded files start with a packet header.
   function automatic void start_pixels();
      gather     = '0;
      gather_pos = '0;
      pkt_count  = '0;
      pkt_run    = 1'b0;
      stage      = rle_file ? PH_PACKET : PH_RAW;
   endfunction

   // One header byte; the last one yields the accepted or rejected header result.
   function automatic bit header_step(input logic [7:0] b, output rsp_item_type res);
      res = '0;
      case (hdr_pos)
         HDR_ID_LEN:     id_skip = b;
         HDR_COLOR_MAP:  if (b != 8'd0) hdr_broken = 1'b1;
         HDR_IMAGE_TYPE: begin
            rle_file = (b == TYPE_RLE_TRUE_COLOR) || (b == TYPE_RLE_GRAY);
            if (!rle_file && b != TYPE_TRUE_COLOR && b != TYPE_GRAY) hdr_broken = 1'b1;
         end
         HDR_WIDTH_LO:   img_w[7:0] = b;
         HDR_WIDTH_HI:   img_w[15:8] = b;
         HDR_HEIGHT_LO:  img_h[7:0] = b;
         HDR_HEIGHT_HI:  img_h[15:8] = b;
         HDR_DEPTH: begin
            if (b == DEPTH_8) bpp = 3'd1;
            else if (b == DEPTH_24) bpp = 3'd3;
            else if (b == DEPTH_32) bpp = 3'd4;
            else begin
               bpp = 3'd0;
               hdr_broken = 1'b1;
            end
         end
         HDR_DESCRIPTOR: top_first = b[DESC_TOP_BIT];
         default: ;
      endcase
      if (hdr_pos < HDR_DESCRIPTOR) begin
         hdr_pos = hdr_pos + 5'd1;
         return 1'b0;
      end
      if (hdr_broken) begin
         res.kind = KIND_HEADER_BAD;
         stage = PH_DONE;
         return 1'b1;
      end
      res.kind         = KIND_HEADER_OK;
      res.image_width  = img_w;
      res.image_height = img_h;
      res.pixel_bytes  = bpp;
      res.top_origin   = top_first;
      res.run_coded    = rle_file;
      // An empty image is complete with its header.
      if (img_w == 16'd0 || img_h == 16'd0) begin
         res.last_of_image = 1'b1;
         stage = PH_DONE;
         return 1'b1;
      end
      pix_remaining = 32'(img_w) * 32'(img_h);
      if (id_skip != 8'd0) stage = PH_ID;
      else start_pixels();
      return 1'b1;
   endfunction

   // Advances the parser by one byte; returns 1 when the byte completes a result.
   function automatic bit decode_byte(input logic [7:0] b, output rsp_item_type res);
      logic [7:0]  reps;
      logic [31:0] granted;
      res = '0;
      case (stage)
         PH_HEADER: return header_step(b, res);
         PH_ID: begin
            id_skip = id_skip - 8'd1;
            if (id_skip == 8'd0) start_pixels();
            return 1'b0;
         end
         PH_PACKET: begin
            pkt_run    = b[7];
            pkt_count  = b[7] ? b - 8'd127 : b + 8'd1;
            gather     = '0;
            gather_pos = '0;
            stage      = PH_PDATA;
            return 1'b0;
         end
         PH_RAW, PH_PDATA: begin
            gather = gather | (32'(b) << (8 * gather_pos));
            if (int'(gather_pos) + 1 < int'(bpp)) begin
               gather_pos = gather_pos + 2'd1;
               return 1'b0;
            end
            reps = 8'd1;
            if (stage == PH_PDATA) begin
               if (pkt_run) begin
                  reps = pkt_count;
                  pkt_count = 8'd0;
               end else begin
                  pkt_count = pkt_count - 8'd1;
               end
               if (pkt_count == 8'd0) stage = PH_PACKET;
            end
            // A packet reaching past the image end is cut to the pixels left.
            granted = (32'(reps) > pix_remaining) ? pix_remaining : 32'(reps);
            pix_remaining = pix_remaining - granted;
            res.kind = KIND_PIXEL;
            res.pixel_value = gather;
            if (bpp > 3'd1)
               res.pixel_value = {gather[31:24], gather[7:0], gather[15:8], gather[23:16]};
            res.repeat_count = granted[7:0];
            if (pix_remaining == 32'd0) begin
               res.last_of_image = 1'b1;
               stage = PH_DONE;
            end
            gather     = '0;
            gather_pos = '0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic string describe(input rsp_item_type r);
      return $sformatf("kind=%0d pixel=%h count=%0d size=%0dx%0d bytes=%0d top=%b coded=%b last=%b",
                       r.kind, r.pixel_value, r.repeat_count, r.image_width, r.image_height,
                       r.pixel_bytes, r.top_origin, r.run_coded, r.last_of_image);
   endfunction

   // Results are checked before bytes are decoded: a result never comes from a byte
   // taken on the same edge.
   always @(posedge clock) begin
      rsp_item_type predicted;
      rsp_item_type got;
      if (reset) begin
         restart_parser();
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            results_seen++;
            if (awaited_results.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("Unexpected result %0d: %s", results_seen, describe(got));
            end else begin
               predicted = awaited_results.pop_front();
               if (got.kind !== predicted.kind || got.pixel_value !== predicted.pixel_value ||
                   got.repeat_count !== predicted.repeat_count ||
                   got.image_width !== predicted.image_width ||
                   got.image_height !== predicted.image_height ||
                   got.pixel_bytes !== predicted.pixel_bytes ||
                   got.top_origin !== predicted.top_origin ||
                   got.run_coded !== predicted.run_coded ||
                   got.last_of_image !== predicted.last_of_image) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("Mismatch on result %0d", results_seen);
                     $display("  expected %s", describe(predicted));
                     $display("  actual   %s", describe(got));
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.new_file) restart_parser();
            if (stage != PH_DONE) live++;
            if (decode_byte(req_data.data_byte, predicted)) begin
               awaited_results.push_back(predicted);
               case (predicted.kind)
                  KIND_PIXEL:     pixels++;
                  KIND_HEADER_OK: headers++;
                  default:        rejects++;
               endcase
            end
         end
      end
      error_count    <= errors;
      pending_count  <= awaited_results.size();
      live_bytes     <= live;
      pixel_count    <= pixels;
      header_count   <= headers;
      rejected_count <= rejects;
   end

endmodule

>>> bench/tga_stream_decoder_core_test.sv
`timescale 1ns / 100ps
// Top of the TGA stream decoder bench: clock, reset, file byte stimulus, result sink
// with random stalls, a watchdog and the verdict. Depends on tgad_pkg,
// tga_stream_decoder_core and tga_stream_decoder_checker.
module tga_stream_decoder_core_test;
   import tgad_pkg::*;

   localparam int ITEM_TARGET    = 600;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   int error_count;
   int pending_count;
   int live_bytes;
   int pixel_count;
   int header_count;
   int rejected_count;

   // Bytes of the file being built, and the sender's pacing for it.
   logic [7:0] file_bytes[$];
   int         file_count = 0;
   bit         send_quiet = 1'b0;
   int         idle_cycles = 0;

   always #5 clock = ~clock;

   tga_stream_decoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   tga_stream_decoder_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .live_bytes     (live_bytes),
      .pixel_count    (pixel_count),
      .header_count   (header_count),
      .rejected_count (rejected_count)
   );

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result sink: random stalls, quiet stretches, and now and then a long hold-off
   // that backs the decoder up into its input.
   initial begin : result_sink
      int hold_cycles;
      int taken;
      bit sink_quiet;
      taken = 0;
      sink_quiet = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0) sink_quiet = ($urandom_range(0, 2) == 0);
         if (taken % 150 == 60) hold_cycles = HOLD_CYCLES;
         else hold_cycles = sink_quiet ? 0 : $urandom_range(0, 3);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic first);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= '{data_byte: value, new_file: first};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Sends the first count bytes of the built file; noisy files carry stray restarts.
   task automatic send_file(input bit mark_first, input int count, input bit noisy);
      logic flag;
      send_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++) begin
         if (i == 0) flag = mark_first;
         else flag = noisy && ($urandom_range(0, 7) == 0);
         send_byte(file_bytes[i], flag);
      end
      file_count++;
   endtask

   task automatic add_noise(input int count);
      repeat (count) file_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // The 18 header bytes followed by the ID field.
   task automatic add_header(input logic [7:0] id_len, input logic [7:0] cmap,
                             input logic [7:0] img_type, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] depth,
                             input logic [7:0] desc);
      file_bytes.push_back(id_len);
      file_bytes.push_back(cmap);
      file_bytes.push_back(img_type);
      add_noise(9);
      file_bytes.push_back(w[7:0]);
      file_bytes.push_back(w[15:8]);
      file_bytes.push_back(h[7:0]);
      file_bytes.push_back(h[15:8]);
      file_bytes.push_back(depth);
      file_bytes.push_back(desc);
      add_noise(int'(id_len));
   endtask

   // Pixel data covering total pixels; run-coded packets may overshoot the end.
   task automatic add_pixels(input bit rle, input int bpp, input int total);
      int left;
      int count;
      left = total;
      while (left > 0) begin
         if (!rle) begin
            add_noise(bpp);
            left--;
         end else if ((left > 16) ? ($urandom_range(0, 4) != 0) :
                                    ($urandom_range(0, 1) == 1)) begin
            count = (left > 8) ? $urandom_range(1, 128) : $urandom_range(1, left + 2);
            file_bytes.push_back(8'(127 + count));
            add_noise(bpp);
            left -= count;
         end else begin
            // Literal packets stay short to keep the byte count down.
            count = $urandom_range(1, (left < 6) ? left + 1 : 6);
            file_bytes.push_back(8'(count - 1));
            add_noise(count * bpp);
            left -= count;
         end
      end
   endtask

   task automatic random_file();
      int         choice;
      int         bpp;
      int         pixels;
      bit         rle;
      logic [7:0] depth;
      logic [7:0] img_type;
      logic [7:0] id_len;
      logic [7:0] odd;
      logic [15:0] w;
      logic [15:0] h;
      file_bytes.delete();
      choice = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
         0:       depth = DEPTH_8;
         1:       depth = DEPTH_24;
         default: depth = DEPTH_32;
      endcase
      bpp = int'(depth) / 8;
      rle = 1'($urandom_range(0, 1));
      if (rle) img_type = $urandom_range(0, 1) ? TYPE_RLE_TRUE_COLOR : TYPE_RLE_GRAY;
      else img_type = $urandom_range(0, 1) ? TYPE_TRUE_COLOR : TYPE_GRAY;
      w = 16'($urandom_range(1, 4));
      h = 16'($urandom_range(1, 4));
      id_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
      if (choice < 60) begin
         // Complete image, now and then a wide run-coded one, then ignored bytes.
         if (rle && $urandom_range(0, 3) == 0) begin
            w = 16'($urandom_range(129, 700));
            h = 16'($urandom_range(1, 2));
         end
         add_header(id_len, 8'd0, img_type, w, h, depth, 8'($urandom_range(0, 255)));
         add_pixels(rle, bpp, int'(w) * int'(h));
         add_noise($urandom_range(0, 2));
         send_file(1'b1, file_bytes.size(), 1'b0);
      end else if (choice < 72) begin
         // File cut off anywhere; the next file restarts the parser.
         if ($urandom_range(0, 2) == 0) begin
            w = 16'hFFFF;
            h = 16'hFFFF;
         end
         add_header(id_len, 8'd0, img_type, w, h, depth, 8'($urandom_range(0, 255)));
         pixels = int'(w) * int'(h);
         add_pixels(rle, bpp, (pixels > 12) ? 12 : pixels);
         send_file(1'b1, $urandom_range(1, file_bytes.size() - 1), 1'b0);
      end else if (choice < 82) begin
         // Header that breaks one rule, or random header bytes.
         case ($urandom_range(0, 3))
            0: add_header(id_len, 8'($urandom_range(1, 255)), img_type, w, h, depth, 8'h00);
            1: begin
               do odd = 8'($urandom_range(0, 255));
               while (odd == TYPE_TRUE_COLOR || odd == TYPE_GRAY ||
                      odd == TYPE_RLE_TRUE_COLOR || odd == TYPE_RLE_GRAY);
               add_header(id_len, 8'd0, odd, w, h, depth, 8'h20);
            end
            2: begin
               do odd = 8'($urandom_range(0, 255));
               while (odd == DEPTH_8 || odd == DEPTH_24 || odd == DEPTH_32);
               add_header(id_len, 8'd0, img_type, w, h, odd, 8'h00);
            end
            default: add_noise(18);
         endcase
         add_noise($urandom_range(0, 4));
         send_file(1'b1, file_bytes.size(), 1'b0);
      end else if (choice < 87) begin
         // Empty image: width or height zero, both sometimes.
         case ($urandom_range(0, 2))
            0:       w = 16'd0;
            1:       h = 16'd0;
            default: begin
               w = 16'd0;
               h = 16'd0;
            end
         endcase
         add_header(id_len, 8'd0, img_type, w, h, depth, 8'($urandom_range(0, 255)));
         add_noise($urandom_range(0, 3));
         send_file(1'b1, file_bytes.size(), 1'b0);
      end else if (choice < 90) begin
         // Long ID field ahead of a small image.
         id_len = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(4, 40));
         add_header(id_len, 8'd0, img_type, w, h, depth, 8'($urandom_range(0, 255)));
         add_pixels(rle, bpp, int'(w) * int'(h));
         send_file(1'b1, file_bytes.size(), 1'b0);
      end else begin
         // Random bytes with stray new-file flags.
         add_noise($urandom_range(4, 30));
         send_file(1'b1, file_bytes.size(), 1'b1);
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First file without a new-file flag: a 128-pixel run cut to the two pixels
      // of the image, then a byte that the finished image ignores.
      file_bytes.delete();
      add_header(8'd0, 8'd0, TYPE_RLE_TRUE_COLOR, 16'd2, 16'd1, DEPTH_24, 8'h20);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h5A);
      file_bytes.push_back(8'hA5);
      send_file(1'b0, file_bytes.size(), 1'b0);

      // Largest image with an ID byte and one pixel, dropped by a restart.
      file_bytes.delete();
      add_header(8'd1, 8'd0, TYPE_TRUE_COLOR, 16'hFFFF, 16'hFFFF, DEPTH_32, 8'hDF);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h00);
      send_file(1'b1, file_bytes.size(), 1'b0);

      // Header that breaks every rule, followed by ignored bytes.
      file_bytes.delete();
      add_header(8'd0, 8'hFF, 8'h01, 16'd4, 16'd4, 8'd16, 8'h00);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hFF);
      send_file(1'b1, file_bytes.size(), 1'b0);

      // Empty image of width zero.
      file_bytes.delete();
      add_header(8'd0, 8'd0, TYPE_GRAY, 16'd0, 16'h8000, DEPTH_8, 8'hFF);
      file_bytes.push_back(8'h42);
      send_file(1'b1, file_bytes.size(), 1'b0);

      // Gray 2x2 run-coded image whose 128-pixel literal packet is cut at the last pixel.
      file_bytes.delete();
      add_header(8'd0, 8'd0, TYPE_RLE_GRAY, 16'd2, 16'd2, DEPTH_8, 8'h00);
      file_bytes.push_back(8'h7F);
      add_noise(6);
      send_file(1'b1, file_bytes.size(), 1'b0);

      while (live_bytes < ITEM_TARGET) random_file();

      // The stream ends in the middle of an image: nothing more may come out.
      file_bytes.delete();
      add_header(8'd0, 8'd0, TYPE_TRUE_COLOR, 16'd3, 16'd3, DEPTH_24, 8'h20);
      add_noise(5);
      send_file(1'b1, file_bytes.size(), 1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d files with %0d decoded bytes under random stalls and long holds.",
               file_count, live_bytes);
      $display("Checked %0d accepted headers, %0d rejected headers and %0d pixel transfers.",
               header_count, rejected_count, pixel_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/tgad_pkg.sv
rtl/tgad_step.sv
rtl/tga_stream_decoder_core.sv
rtl/tgad_checker.sv
bench/tga_stream_decoder_checker.sv
bench/tga_stream_decoder_core_test.sv
